// File: rtl/core/kre_pkg.sv
// Package for the k-mer rolling encoder: item types, widths and constants.
`default_nettype none

package kre_pkg;

	// field widths fixed by the item formats
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 32;
	localparam int CODE_W  = 26;
	localparam int SKIP_W  = 8;

	// default k-mer length in bases
	localparam int KMER_LEN_DEF = 13;

	// base character that marks an unknown base
	localparam logic [CHAR_W-1:0] BASE_UNKNOWN = 8'h4E;

	// one input item: a sequence character
	typedef struct packed {
		logic [CHAR_W-1:0] base_char;
		logic              last_base;
		logic [POS_W-1:0]  start_offset;
	} base_item_t;

	// one result item: an emitted k-mer and its start position
	typedef struct packed {
		logic [CODE_W-1:0] kmer_code;
		logic [POS_W-1:0]  kmer_position;
	} kmer_item_t;

endpackage

`default_nettype wire

// File: rtl/core/kmer_rolling_encoder_top.sv
// Top level of the k-mer rolling encoder.
//
// Usage:
//   Bases enter on the base channel (base_valid / base_stall / base_item), one
//   character per item. Emitted k-mers leave on the kmer channel (kmer_valid /
//   kmer_stall / kmer_item). An item moves when valid is high and stall is low.
//   The skip interval is written on the cfg channel (cfg_valid / cfg_ready /
//   cfg_skip_interval); cfg_ready is always high. Write it only while idle.
// Result path: an accepted base loads the input register; a base that
//   completes an emitted k-mer then loads the result register, which
//   drives kmer_valid and kmer_item.
// Throughput: one base per cycle unless kmer_stall holds a result; all the
//   per-base work (2-bit code, shift, fill and skip counters, position add)
//   sits between the input and result registers.
// Stall: while kmer_stall holds a pending result the input register holds;
//   base_stall rises only when both registers are occupied.
// Reset: arst_n clears both valid bits, the k-mer state and the skip
//   interval (to zero); items are accepted in the first cycle after reset.
`default_nettype none

module kmer_rolling_encoder_top #(
	parameter int KMER_LEN = kre_pkg::KMER_LEN_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// base channel
	input  wire                           base_valid,
	output logic                          base_stall,
	input  kre_pkg::base_item_t           base_item,
	// k-mer channel
	output logic                          kmer_valid,
	input  wire                           kmer_stall,
	output kre_pkg::kmer_item_t           kmer_item,
	// configuration channel
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [kre_pkg::SKIP_W-1:0]     cfg_skip_interval
);
	import kre_pkg::*;

	localparam int KW = 2 * KMER_LEN;
	localparam int FW = $clog2(KMER_LEN + 1);
	localparam int EW = (KW > CODE_W) ? KW : CODE_W;

	// configuration register
	logic [SKIP_W-1:0] skip_interval_q;

	// sequence state
	logic [KW-1:0]     kmer_q;
	logic [FW-1:0]     fill_q;
	logic [SKIP_W-1:0] skip_q;
	logic [POS_W-1:0]  index_q;
	logic              in_seq_q;

	// pipeline registers
	base_item_t item_s1;
	logic       valid_s1;
	kmer_item_t item_s2;
	logic       valid_s2;

	// per-base next values
	logic              adv;
	logic              is_unknown;
	logic [1:0]        base_code;
	logic [POS_W-1:0]  pos;
	logic [SKIP_W-1:0] skip_cur;
	logic [KW-1:0]     kmer_shl;
	logic [KW-1:0]     kmer_nx;
	logic [FW-1:0]     fill_nx;
	logic [SKIP_W-1:0] skip_nx;
	logic              emit;
	logic [EW-1:0]     code_ext;

	assign cfg_ready = 1'b1;

	// handshake: stage 1 moves on when the result register is free or drained
	assign adv        = valid_s1 && (!valid_s2 || !kmer_stall);
	assign base_stall = valid_s1 && !adv;
	assign kmer_valid = valid_s2;
	assign kmer_item  = item_s2;

	// one base: code, shift, counters, position
	always_comb begin
		is_unknown = (item_s1.base_char == BASE_UNKNOWN);
		base_code  = item_s1.base_char[2:1];
		pos        = in_seq_q ? index_q : item_s1.start_offset;
		skip_cur   = in_seq_q ? skip_q : skip_interval_q;
		kmer_shl   = kmer_q << 2;
		kmer_nx    = kmer_shl | KW'(base_code);
		fill_nx    = (fill_q < FW'(KMER_LEN)) ? fill_q + FW'(1) : fill_q;
		emit       = 1'b0;
		skip_nx    = skip_cur;
		if (is_unknown) begin
			kmer_nx = '0;
			fill_nx = '0;
			skip_nx = skip_interval_q;
		end else if (fill_nx == FW'(KMER_LEN)) begin
			if (skip_cur == skip_interval_q) begin
				emit    = 1'b1;
				skip_nx = '0;
			end else begin
				skip_nx = skip_cur + SKIP_W'(1);
			end
		end
		code_ext = EW'(kmer_nx);
	end

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_interval_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			skip_interval_q <= cfg_skip_interval;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!base_stall) begin
			valid_s1 <= base_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (base_valid && !base_stall) begin
			item_s1 <= base_item;
		end
	end

	// sequence state update; last base clears k-mer state, skip_q gets the interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q   <= '0;
			fill_q   <= '0;
			skip_q   <= '0;
			index_q  <= '0;
			in_seq_q <= 1'b0;
		end else if (adv) begin
			if (item_s1.last_base) begin
				kmer_q   <= '0;
				fill_q   <= '0;
				skip_q   <= skip_interval_q;
				index_q  <= '0;
				in_seq_q <= 1'b0;
			end else begin
				kmer_q   <= kmer_nx;
				fill_q   <= fill_nx;
				skip_q   <= skip_nx;
				index_q  <= pos + POS_W'(1);
				in_seq_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && emit) begin
			valid_s2 <= 1'b1;
		end else if (!kmer_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			item_s2.kmer_code     <= code_ext[CODE_W-1:0];
			item_s2.kmer_position <= pos + POS_W'(1) - POS_W'(KMER_LEN);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/kre_checker.sv
// Port-level checker for the k-mer rolling encoder, bound to the top level.
`default_nettype none

module kre_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       base_stall,
	input wire                       kmer_valid,
	input wire                       kmer_stall,
	input kre_pkg::kmer_item_t       kmer_item,
	input wire                       cfg_valid,
	input wire                       cfg_ready
);
	import kre_pkg::*;

	// nothing is pending in the first cycle after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !kmer_valid && !base_stall)
		else $error("result or stall present right after reset");

	// input stalls only when a result is held by the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		base_stall |-> kmer_valid && kmer_stall)
		else $error("base channel stalled without a held result");

	// configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kmer_valid && kmer_stall |=> kmer_valid && $stable(kmer_item))
		else $error("stalled k-mer item changed");

endmodule

bind kmer_rolling_encoder_top kre_checker u_kre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.base_stall (base_stall),
	.kmer_valid (kmer_valid),
	.kmer_stall (kmer_stall),
	.kmer_item  (kmer_item),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire
